/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the barrier tracker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define BAT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define BAT_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/core/bat_pkg.sv */
// ---------------------------------------------------------------------------
// Barrier arrival tracker package
// Field widths, command and status codes, and controller command type.
// ---------------------------------------------------------------------------
`default_nettype none

package bat_pkg;

  localparam int CMD_W      = 1;
  localparam int ID_W       = 32;
  localparam int SENDER_W   = 4;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int NODE_CFG_W = 5;

  // Number of distinct sender numbers the sender field can carry.
  localparam int SENDER_SPAN = 2 ** SENDER_W;

  localparam logic [NODE_CFG_W-1:0] NODE_COUNT_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_NOTIFY = 1'b0;
  localparam logic [CMD_W-1:0] CMD_WAIT   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PENDING   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted transaction
    logic lookup;   // match the id against the slot table, issue the RAM read
    logic exec;     // apply the update and load the result register
  } bat_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/bat_ifs.sv */
// ---------------------------------------------------------------------------
// Barrier arrival tracker channel interfaces
// Valid/ready channels for request and result transactions.
// ---------------------------------------------------------------------------
`default_nettype none

interface bat_in_if import bat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ID_W-1:0]     sync_id;
  logic [SENDER_W-1:0] sender_node;

  modport source (output valid, command, sync_id, sender_node, input ready);
  modport sink   (input valid, command, sync_id, sender_node, output ready);
endinterface

interface bat_out_if import bat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  arrived_count;

  modport source (output valid, status, arrived_count, input ready);
  modport sink   (input valid, status, arrived_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/bat_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bat_ctrl.sv */
// ---------------------------------------------------------------------------
// Barrier arrival tracker controller
// Sequences accept, lookup and execute, and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bat_ctrl import bat_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output bat_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_EXEC   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  // The result register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign cmd_o.capture = in_valid && in_ready;
  assign cmd_o.lookup  = (state_r == ST_LOOKUP);
  assign cmd_o.exec    = (state_r == ST_EXEC) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_o.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BAT_ASSERT_RST(a_reset_to_idle, clk, !rst_n |=> state_r == ST_IDLE, "controller not idle after reset")
  `BAT_ASSERT(a_accept_to_lookup, clk, rst_n, cmd_o.capture |=> state_r == ST_LOOKUP, "accepted transaction did not enter lookup")
  `BAT_ASSERT(a_exec_sets_valid, clk, rst_n, cmd_o.exec |=> out_valid_r, "executed transaction produced no result")

endmodule

`default_nettype wire

/* rtl/core/bat_datapath.sv */
// ---------------------------------------------------------------------------
// Barrier arrival tracker datapath
// Slot table with id match, arrival map/count RAM, and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bat_datapath import bat_pkg::*; #(
  parameter int BARRIER_SLOTS = 8,
  parameter int MAX_NODES     = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bat_cmd_t              cmd_i,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [ID_W-1:0]       in_sync_id,
  input  wire logic [SENDER_W-1:0]   in_sender_node,
  input  wire logic                  cfg_wr_en,
  input  wire logic [NODE_CFG_W-1:0] cfg_wr_data,
  output logic      [STATUS_W-1:0]   out_status,
  output logic      [COUNT_W-1:0]    out_arrived_count
);

  // Only senders the sender field can name ever set a map bit.
  localparam int MAP_W   = (MAX_NODES < SENDER_SPAN) ? MAX_NODES : SENDER_SPAN;
  localparam int BIT_W   = $clog2(MAP_W);
  localparam int SLOT_W  = (BARRIER_SLOTS > 1) ? $clog2(BARRIER_SLOTS) : 1;
  localparam int ENTRY_W = MAP_W + COUNT_W;
  localparam int CFG_MAX = (2 ** NODE_CFG_W) - 1;
  localparam logic [NODE_CFG_W-1:0] TARGET_MAX =
    NODE_CFG_W'((MAX_NODES > CFG_MAX) ? CFG_MAX : MAX_NODES);

  // Captured transaction
  logic [CMD_W-1:0]      cmd_r;
  logic [ID_W-1:0]       id_r;
  logic [SENDER_W-1:0]   sender_r;
  logic [NODE_CFG_W-1:0] node_count_r;

  // Slot table
  logic [BARRIER_SLOTS-1:0] slot_valid_r;
  logic [BARRIER_SLOTS-1:0] slot_valid_nxt;
  logic [ID_W-1:0]          slot_id_r [BARRIER_SLOTS];

  // Lookup results
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              free;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] slot_sel;
  logic              hit_r;
  logic              free_r;
  logic [SLOT_W-1:0] slot_r;

  // Execute stage
  logic [ENTRY_W-1:0]    rd_entry;
  logic [ENTRY_W-1:0]    wr_entry;
  logic [MAP_W-1:0]      base_map;
  logic [COUNT_W-1:0]    base_cnt;
  logic [MAP_W-1:0]      bit_mask;
  logic [NODE_CFG_W-1:0] target;
  logic                  range_err;
  logic                  dup;
  logic                  wr_en;
  logic                  alloc;
  logic                  complete;
  logic [MAP_W-1:0]      new_map;
  logic [COUNT_W-1:0]    new_cnt;
  logic [STATUS_W-1:0]   exec_status;
  logic [COUNT_W-1:0]    exec_count;

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_r    <= in_command;
      id_r     <= in_sync_id;
      sender_r <= in_sender_node;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  // Ids are unique among valid slots, so the match order does not matter.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < BARRIER_SLOTS; i++) begin
      if (slot_valid_r[i] && (slot_id_r[i] == id_r)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  // Lowest-numbered free slot.
  always_comb begin
    free     = 1'b0;
    free_idx = '0;
    for (int i = BARRIER_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free     = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign slot_sel = hit ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (cmd_i.lookup) begin
      hit_r  <= hit;
      free_r <= free;
      slot_r <= slot_sel;
    end
  end

  bat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BARRIER_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd_i.exec && wr_en),
    .waddr (slot_r),
    .wdata (wr_entry),
    .re    (cmd_i.lookup),
    .raddr (slot_sel),
    .rdata (rd_entry)
  );

  // A freshly allocated slot starts from an empty map and a zero count.
  assign base_map = hit_r ? rd_entry[ENTRY_W-1:COUNT_W] : '0;
  assign base_cnt = hit_r ? rd_entry[COUNT_W-1:0] : '0;

  // Target is the node count clamped to one through the node limit.
  always_comb begin
    target = node_count_r;
    if (target == '0) begin
      target = NODE_CFG_W'(1);
    end else if (target > TARGET_MAX) begin
      target = TARGET_MAX;
    end
  end

  assign range_err = (cmd_r == CMD_NOTIFY) && (NODE_CFG_W'(sender_r) >= target);
  // Only used when the sender is below the target, hence inside the map.
  assign bit_mask  = MAP_W'(1) << sender_r[BIT_W-1:0];
  assign dup       = |(base_map & bit_mask);

  always_comb begin
    exec_status = ST_PENDING;
    exec_count  = base_cnt;
    wr_en       = 1'b0;
    alloc       = 1'b0;
    complete    = 1'b0;
    new_map     = base_map;
    new_cnt     = base_cnt;
    if (range_err) begin
      exec_status = ST_RANGE;
    end else if (!hit_r && !free_r) begin
      exec_status = ST_FULL;
      exec_count  = '0;
    end else begin
      wr_en = 1'b1;
      alloc = !hit_r;
      if (cmd_r == CMD_NOTIFY) begin
        if (dup) begin
          exec_status = ST_DUPLICATE;
        end else begin
          new_map    = base_map | bit_mask;
          new_cnt    = base_cnt + COUNT_W'(1);
          exec_count = new_cnt;
        end
      end else if (NODE_CFG_W'(base_cnt) >= target) begin
        exec_status = ST_COMPLETE;
        complete    = 1'b1;
      end
    end
  end

  assign wr_entry = {new_map, new_cnt};

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    if (cmd_i.exec) begin
      if (alloc) begin
        slot_valid_nxt[slot_r] = 1'b1;
      end
      if (complete) begin
        slot_valid_nxt[slot_r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.exec && alloc) begin
      slot_id_r[slot_r] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.exec) begin
      out_status        <= exec_status;
      out_arrived_count <= exec_count;
    end
  end

  `BAT_ASSERT(a_full_means_all_valid, clk, rst_n, (cmd_i.exec && exec_status == ST_FULL) |-> (&slot_valid_r), "table full reported with a free slot")
  `BAT_ASSERT(a_complete_frees_slot, clk, rst_n, (cmd_i.exec && exec_status == ST_COMPLETE) |=> !slot_valid_r[$past(slot_r)], "completed barrier slot not freed")
  `BAT_ASSERT(a_valid_only_on_exec, clk, rst_n, !cmd_i.exec |=> $stable(slot_valid_r), "slot table changed outside execute")

endmodule

`default_nettype wire

/* rtl/core/barrier_arrival_tracker_top.sv */
// ---------------------------------------------------------------------------
// Barrier arrival tracker
// Tracks node arrivals for several barriers at once, keyed by barrier id.
// ---------------------------------------------------------------------------
// Each request transaction is an arrival notify or a wait poll for one
// barrier id and yields exactly one result transaction with a status code
// and the barrier's arrival count. A transaction passes through the
// accept cycle, a lookup cycle in which the id is compared against every
// slot in parallel and the slot's arrival map and count are read from the
// entry RAM, and an execute cycle that applies the update and loads the
// result register. The next request is accepted in the cycle after execute,
// so a new request is not taken until the previous one has executed;
// execute waits while a previous result is still held in the result register
// and not taken. The registered read of the entry RAM and a controller that
// handles one transaction at a time set this pacing. A notify allocates the
// lowest free slot when its barrier has none; a wait poll allocates too,
// and reports completion and frees the slot once the count reaches
// node_count clamped to one through MAX_NODES. Duplicate senders, senders
// at or above the target and a full table are reported as status codes
// without changing the table. node_count is written through
// cfg_wr_en/cfg_wr_data and must only be changed while the block is idle.
// No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module barrier_arrival_tracker_top import bat_pkg::*; #(
  parameter int BARRIER_SLOTS = 8,   // concurrent barriers, 1 to 64
  parameter int MAX_NODES     = 16   // upper limit of the node count, 2 to 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bat_in_if.sink                     in_ch,
  bat_out_if.source                  out_ch,
  input  wire logic                  cfg_wr_en,
  input  wire logic [NODE_CFG_W-1:0] cfg_wr_data
);

  // Command bundle from the controller to the datapath.
  bat_cmd_t cmd;

  // The controller paces the transaction and owns both handshakes.
  bat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd_o     (cmd)
  );

  // The datapath holds the slot table, the entry RAM, the node count
  // register and the result payload register.
  bat_datapath #(
    .BARRIER_SLOTS (BARRIER_SLOTS),
    .MAX_NODES     (MAX_NODES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (cmd),
    .in_command        (in_ch.command),
    .in_sync_id        (in_ch.sync_id),
    .in_sender_node    (in_ch.sender_node),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_status        (out_ch.status),
    .out_arrived_count (out_ch.arrived_count)
  );

endmodule

`default_nettype wire

/* bench/barrier_arrival_tracker_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Barrier arrival tracker testbench
// Drives notify and wait transactions into the tracker and checks every
// result against a cycle-free model of the barrier table kept in the bench.
// ---------------------------------------------------------------------------

module barrier_arrival_tracker_top_tb;
  import bat_pkg::*;

  localparam int SLOTS        = 8;
  localparam int MAX_NODES    = 16;
  localparam int POOL_SIZE    = 10;
  localparam int CYCLE_LIMIT  = 500000;
  // The block handles one transaction at a time, so these idle cycles
  // are plenty for anything still in flight to show up.
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  arrived_count;
  } barrier_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [NODE_CFG_W-1:0] cfg_wr_data;

  bat_in_if  in_ch ();
  bat_out_if out_ch ();

  barrier_arrival_tracker_top #(
    .BARRIER_SLOTS(SLOTS),
    .MAX_NODES    (MAX_NODES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Bench copy of the barrier table and of the node count register.
  logic                  slot_used  [SLOTS];
  logic [ID_W-1:0]       slot_id    [SLOTS];
  logic [MAX_NODES-1:0]  slot_map   [SLOTS];
  logic [COUNT_W-1:0]    slot_count [SLOTS];
  logic [NODE_CFG_W-1:0] tracked_node_count;

  // Results predicted for accepted transactions, oldest first.
  barrier_result_t awaited_results [$];

  // Barrier ids that the random traffic keeps coming back to.
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  bit          src_idle_en   = 1'b1;
  bit          snk_idle_en   = 1'b1;
  int unsigned stall_request = 0;
  bit          stall_active  = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is cut off here if the block ever stops producing results.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("barrier_arrival_tracker_top_tb NOT OK");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Table model
  // -------------------------------------------------------------------------

  // The node count is clamped to one through MAX_NODES, so zero acts as one
  // and anything above MAX_NODES acts as MAX_NODES.
  function automatic int effective_target();
    if (tracked_node_count < 1) return 1;
    if (tracked_node_count > MAX_NODES) return MAX_NODES;
    return tracked_node_count;
  endfunction

  function automatic int find_barrier(input logic [ID_W-1:0] id);
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_used[s] && slot_id[s] == id) return s;
    end
    return -1;
  endfunction

  // Applies one accepted transaction to the bench table and returns the
  // result that the block must produce for it.
  function automatic barrier_result_t predict_barrier_item(
    input logic [CMD_W-1:0]    cmd,
    input logic [ID_W-1:0]     id,
    input logic [SENDER_W-1:0] sender
  );
    barrier_result_t res;
    int              target_n;
    int              hit;
    int              slot;
    target_n          = effective_target();
    hit               = find_barrier(id);
    res.status        = ST_PENDING;
    res.arrived_count = '0;
    if (cmd == CMD_NOTIFY && sender >= target_n) begin
      // A sender out of range touches nothing, not even a missing slot.
      res.status = ST_RANGE;
      if (hit >= 0) res.arrived_count = slot_count[hit];
    end else begin
      slot = hit;
      if (slot < 0) begin
        // Claim the lowest free slot for a barrier seen for the first time.
        for (int s = 0; s < SLOTS; s++) begin
          if (slot < 0 && !slot_used[s]) begin
            slot          = s;
            slot_used[s]  = 1'b1;
            slot_id[s]    = id;
            slot_map[s]   = '0;
            slot_count[s] = '0;
          end
        end
      end
      if (slot < 0) begin
        res.status = ST_FULL;
      end else if (cmd == CMD_NOTIFY) begin
        if (slot_map[slot][sender]) begin
          res.status = ST_DUPLICATE;
        end else begin
          slot_map[slot][sender] = 1'b1;
          slot_count[slot]       = slot_count[slot] + 1'b1;
        end
        res.arrived_count = slot_count[slot];
      end else begin
        // Only a wait poll reports completion, and it frees the slot.
        res.arrived_count = slot_count[slot];
        if (slot_count[slot] >= target_n) begin
          res.status      = ST_COMPLETE;
          slot_used[slot] = 1'b0;
        end
      end
    end
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus and handshake helpers
  // -------------------------------------------------------------------------

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one transaction and waits for it to be accepted. The task is
  // entered at a rising edge and returns at the accepting edge with valid
  // still high, so a following call can present the next transaction in
  // the same step without dropping valid.
  task automatic send_item(
    input logic [CMD_W-1:0]    cmd,
    input logic [ID_W-1:0]     id,
    input logic [SENDER_W-1:0] sender
  );
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.sync_id     <= id;
    in_ch.sender_node <= sender;
    do @(posedge clk); while (!in_ch.ready);
    awaited_results.push_back(predict_barrier_item(cmd, id, sender));
  endtask

  // Builds a mostly well-formed transaction from the current table: it
  // tends to revisit live barriers, to pick senders that have not arrived
  // yet and to poll barriers that have reached their target. The rest is
  // noise: fresh ids, duplicates and senders out of range.
  task automatic send_random_item();
    int                  live [$];
    int                  missing [$];
    int                  hit;
    int                  target_n;
    int                  roll;
    logic [ID_W-1:0]     id;
    logic [CMD_W-1:0]    cmd;
    logic [SENDER_W-1:0] sender;
    foreach (slot_used[s]) begin
      if (slot_used[s]) live.push_back(s);
    end
    roll = $urandom_range(0, 99);
    if (roll < 60 && live.size() != 0) begin
      id = slot_id[live[$urandom_range(0, live.size() - 1)]];
    end else if (roll < 97) begin
      id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else begin
      id = $urandom;
    end
    hit      = find_barrier(id);
    target_n = effective_target();
    for (int n = 0; n < target_n; n++) begin
      if (hit < 0 || !slot_map[hit][n]) missing.push_back(n);
    end
    if (hit >= 0 && slot_count[hit] >= target_n) begin
      cmd = ($urandom_range(0, 9) < 7) ? CMD_WAIT : CMD_NOTIFY;
    end else begin
      cmd = ($urandom_range(0, 3) == 0) ? CMD_WAIT : CMD_NOTIFY;
    end
    if (missing.size() != 0 && $urandom_range(0, 9) < 8) begin
      sender = SENDER_W'(missing[$urandom_range(0, missing.size() - 1)]);
    end else begin
      sender = SENDER_W'($urandom_range(0, SENDER_SPAN - 1));
    end
    send_item(cmd, id, sender);
  endtask

  // Drops valid and waits until every predicted result has come back, then
  // a few more cycles so that the block is fully idle.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_node_count(input logic [NODE_CFG_W-1:0] value);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    tracked_node_count = value;
    cfg_wr_en <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Result side
  // -------------------------------------------------------------------------

  // The receiver accepts most cycles and idles at random while idling is
  // enabled. A test can ask for one long hold-off, which this process
  // counts out on its own while the sender keeps offering transactions.
  initial begin : result_sink
    int unsigned hold;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        hold          = stall_request;
        stall_request = 0;
        stall_active  = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
        stall_active  = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted result transaction is compared with the oldest
  // prediction. Outputs are sampled at the edge, before the block updates.
  always @(posedge clk) begin : check_results
    barrier_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing expected: status %0d arrived_count %0d",
               out_ch.status, out_ch.arrived_count);
        error_count++;
      end else begin
        exp_res = awaited_results.pop_front();
        if (out_ch.status !== exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 exp_res.status, out_ch.status);
          error_count++;
        end
        if (out_ch.arrived_count !== exp_res.arrived_count) begin
          $error("arrived_count mismatch: expected %0d, actual %0d",
                 exp_res.arrived_count, out_ch.arrived_count);
          error_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // With the reset node count of sixteen: a first arrival, the same sender
  // again, the top sender on the all-ones id and a poll that stays pending.
  task automatic test_reset_defaults();
    send_item(CMD_NOTIFY, 32'h0000_0000, 4'd0);
    send_item(CMD_NOTIFY, 32'h0000_0000, 4'd0);
    send_item(CMD_NOTIFY, 32'hFFFF_FFFF, 4'd15);
    send_item(CMD_WAIT,   32'h0000_0000, 4'd0);
  endtask

  // A target of two: the barrier on id zero fills up, senders at or above
  // the target are rejected with and without a slot, the poll completes
  // and frees the slot, and a poll on an unknown id allocates one.
  task automatic test_completion_and_range();
    program_node_count(5'd2);
    send_item(CMD_NOTIFY, 32'h0000_0000, 4'd1);
    send_item(CMD_NOTIFY, 32'h0000_0005, 4'd2);
    send_item(CMD_NOTIFY, 32'h0000_0000, 4'd15);
    send_item(CMD_WAIT,   32'h0000_0000, 4'd0);
    send_item(CMD_WAIT,   32'h0000_0007, 4'd0);
  endtask

  // Two slots are in use at this point, so six polls fill the table. A new
  // barrier is then turned away for both commands, while a barrier that
  // already owns a slot still gets through.
  task automatic test_table_full();
    for (int n = 0; n < 6; n++) send_item(CMD_WAIT, 32'd100 + n, 4'd0);
    send_item(CMD_WAIT,   32'd200, 4'd0);
    send_item(CMD_NOTIFY, 32'd201, 4'd0);
    send_item(CMD_NOTIFY, 32'd100, 4'd1);
  endtask

  // A node count of zero acts as one. The all-ones barrier was started
  // under a target of sixteen and must now complete on its next poll.
  task automatic test_target_lowered();
    program_node_count(5'd0);
    send_item(CMD_NOTIFY, 32'hFFFF_FFFF, 4'd0);
    send_item(CMD_WAIT,   32'hFFFF_FFFF, 4'd0);
    send_item(CMD_NOTIFY, 32'h0000_0007, 4'd1);
  endtask

  // Random traffic under a series of node counts, the extremes and values
  // outside the legal range among them. Idling on each side is switched
  // per phase so that two phases run with no gaps at all.
  task automatic test_random_settings();
    logic [NODE_CFG_W-1:0] settings [8];
    settings = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd9, 5'd17, 5'd2};
    for (int p = 0; p < POOL_SIZE; p++) id_pool[p] = $urandom;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'h8000_0000;
    // Two ids that differ in one bit, so a partial match would show.
    id_pool[4] = id_pool[3] ^ 32'h0001_0000;
    for (int k = 0; k < 8; k++) begin
      program_node_count(settings[k]);
      src_idle_en = (k % 2 == 0);
      snk_idle_en = (k % 4 < 2);
      repeat (75) send_random_item();
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  // The receiver holds off for a long stretch while transactions are
  // offered back to back, so the result register fills up and the block
  // has to stall its input.
  task automatic test_input_stall();
    in_ch.valid  <= 1'b0;
    src_idle_en   = 1'b0;
    stall_request = 300;
    wait (stall_active);
    @(posedge clk);
    repeat (20) send_random_item();
    src_idle_en = 1'b1;
  endtask

  initial begin : run_tests
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s]  = 1'b0;
      slot_id[s]    = '0;
      slot_map[s]   = '0;
      slot_count[s] = '0;
    end
    tracked_node_count = NODE_COUNT_RESET;

    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_NOTIFY;
    in_ch.sync_id     <= '0;
    in_ch.sender_node <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_completion_and_range();
    test_table_full();
    test_target_lowered();
    test_random_settings();
    test_input_stall();

    // Everything has been sent; wait for the last results and a short tail
    // in which any stray transaction would be flagged by the checker.
    settle_block();
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("barrier_arrival_tracker_top_tb OK");
    end else begin
      $display("barrier_arrival_tracker_top_tb NOT OK");
    end
    $finish;
  end

endmodule
